// ===== hw/rtl/pwrfe_pkg.sv =====
// Shared types and constants for the pulse-width radio frame encoder.
package pwrfe_pkg;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SEND = 1'b1;

	localparam logic CFG_FRAMES = 1'b0;
	localparam logic CFG_PERIOD = 1'b1;

	localparam int CFG_DATA_W = 8;

	localparam logic [3:0] FRAMES_RESET = 4'd4;
	localparam logic [7:0] PERIOD_RESET = 8'd184;

	localparam int          PRE_LEN     = 11;
	localparam logic [10:0] PRE_PATTERN = 11'b10101011110;
	localparam int          STOP_LEN     = 5;
	localparam logic [4:0]  STOP_PATTERN = 5'b11110;

	localparam int BIT_POS_W = 7;

	typedef enum logic [3:0] {
		SEQ_PRE  = 4'b0001,
		SEQ_SYM  = 4'b0010,
		SEQ_STOP = 4'b0100,
		SEQ_DONE = 4'b1000
	} seq_t;

	typedef struct packed {
		logic line_data;
		logic tx_active;
		logic busy_res;
		logic send_dropped;
	} res_t;

endpackage

// ===== hw/rtl/pwrfe_core.sv =====
// Frame sequencer: encoder state and per-word update.
module pwrfe_core #(
	parameter int FRAME_STORE_BYTES = 16,
	parameter int BODY_BITS         = 28
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              op,
	input  logic [31:0]       message_word,
	input  logic [3:0]        frames_per_message,
	input  logic [7:0]        frame_period_ticks,
	output pwrfe_pkg::res_t   res
);
	import pwrfe_pkg::*;

	localparam int STORE_BITS = FRAME_STORE_BYTES * 8;
	localparam int SYM_W      = $clog2(BODY_BITS + 1);

	logic [BODY_BITS-1:0] body_q, body_d, shift_q, shift_d;
	logic                 parity_q, parity_d;
	logic [3:0]           frames_left_q, frames_left_d;
	logic [7:0]           period_q, period_d;
	logic                 tx_q, tx_d;
	logic                 line_q, line_d;
	logic [BIT_POS_W-1:0] bit_pos_q, bit_pos_d;
	seq_t                 seq_q, seq_d;
	logic [3:0]           cnt_q, cnt_d;
	logic [SYM_W-1:0]     sym_q, sym_d;
	logic [1:0]           sub_q, sub_d;

	logic busy, start, dropped, sym_one, sym_end, last_sym, bit_val;

	always_comb begin
		last_sym = (sym_q == SYM_W'(BODY_BITS));
		sym_one  = last_sym ? parity_q : shift_q[BODY_BITS-1];
		sym_end  = sym_one ? (sub_q == 2'd2) : (sub_q == 2'd1);
		busy     = tx_q || (frames_left_q != 4'd0);

		unique case (seq_q)
			SEQ_PRE:  bit_val = PRE_PATTERN[4'(PRE_LEN - 1) - cnt_q];
			SEQ_SYM:  bit_val = (sub_q == 2'd0) ? 1'b1 : ((sub_q == 2'd1) ? sym_one : 1'b0);
			SEQ_STOP: bit_val = STOP_PATTERN[3'(STOP_LEN - 1) - cnt_q[2:0]];
			default:  bit_val = 1'b0;
		endcase
	end

	always_comb begin
		body_d        = body_q;
		shift_d       = shift_q;
		parity_d      = parity_q;
		frames_left_d = frames_left_q;
		period_d      = period_q;
		tx_d          = tx_q;
		line_d        = line_q;
		bit_pos_d     = bit_pos_q;
		seq_d         = seq_q;
		cnt_d         = cnt_q;
		sym_d         = sym_q;
		sub_d         = sub_q;
		start         = 1'b0;
		dropped       = 1'b0;

		if (op == OP_SEND) begin
			if (busy) begin
				dropped = 1'b1;
			end else begin
				body_d        = message_word[31 -: BODY_BITS];
				parity_d      = ^message_word[31 -: BODY_BITS];
				frames_left_d = (frames_per_message == 4'd0) ? 4'd1 : frames_per_message;
				start         = 1'b1;
			end
		end else begin
			if (tx_q) begin
				if (seq_q != SEQ_DONE) begin
					line_d    = (int'(bit_pos_q) < STORE_BITS) ? bit_val : 1'b0;
					bit_pos_d = bit_pos_q + 1'b1;
					unique case (seq_q)
						SEQ_PRE: begin
							if (cnt_q == 4'(PRE_LEN - 1)) begin
								seq_d = SEQ_SYM;
								sym_d = '0;
								sub_d = 2'd0;
							end else begin
								cnt_d = cnt_q + 4'd1;
							end
						end
						SEQ_SYM: begin
							if (sym_end) begin
								sub_d   = 2'd0;
								shift_d = shift_q << 1;
								if (last_sym) begin
									seq_d = SEQ_STOP;
									cnt_d = 4'd0;
								end else begin
									sym_d = sym_q + 1'b1;
								end
							end else begin
								sub_d = sub_q + 2'd1;
							end
						end
						SEQ_STOP: begin
							if (cnt_q == 4'(STOP_LEN - 1)) begin
								seq_d = SEQ_DONE;
							end else begin
								cnt_d = cnt_q + 4'd1;
							end
						end
						default: seq_d = SEQ_DONE;
					endcase
				end else begin
					tx_d   = 1'b0;
					line_d = 1'b0;
				end
			end
			if (period_q != 8'hFF) begin
				period_d = period_q + 8'd1;
			end
			if (!tx_d && (frames_left_q != 4'd0) && (period_d >= frame_period_ticks)) begin
				start = 1'b1;
			end
		end

		if (start) begin
			tx_d          = 1'b1;
			bit_pos_d     = '0;
			period_d      = 8'd0;
			seq_d         = SEQ_PRE;
			cnt_d         = 4'd0;
			sym_d         = '0;
			sub_d         = 2'd0;
			shift_d       = body_d;
			frames_left_d = frames_left_d - 4'd1;
		end

		res.line_data    = line_d;
		res.tx_active    = tx_d;
		res.busy_res     = tx_d || (frames_left_d != 4'd0);
		res.send_dropped = dropped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_left_q <= 4'd0;
			period_q      <= 8'd0;
			tx_q          <= 1'b0;
			line_q        <= 1'b0;
			bit_pos_q     <= '0;
			seq_q         <= SEQ_DONE;
			cnt_q         <= 4'd0;
			sym_q         <= '0;
			sub_q         <= 2'd0;
		end else if (step) begin
			frames_left_q <= frames_left_d;
			period_q      <= period_d;
			tx_q          <= tx_d;
			line_q        <= line_d;
			bit_pos_q     <= bit_pos_d;
			seq_q         <= seq_d;
			cnt_q         <= cnt_d;
			sym_q         <= sym_d;
			sub_q         <= sub_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			body_q   <= body_d;
			shift_q  <= shift_d;
			parity_q <= parity_d;
		end
	end

endmodule

// ===== hw/rtl/pulse_width_radio_frame_encoder.sv =====
// Top level: handshakes, configuration registers and result register.
//
// Input channel (in_valid/in_ready, op, message_word): op 0 is one bit-period
// tick, op 1 requests a send of message_word bits 31 down to 32-BODY_BITS.
// Each accepted word produces exactly one result word on the output channel
// (out_valid/out_ready): line level, radio enable, busy and a flag for a send
// dropped because a message was still going out.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0
// sets frames per message, index 1 sets the minimum frame period in ticks.
// cfg_ready is always high; write only while the block is idle.
// The result word is registered and is valid in the cycle after the input word
// is taken. Throughput: one word per cycle while the receiver keeps up; the
// whole update is one pass of logic between the encoder state and result registers.
// When the receiver stalls, the result register holds and in_ready drops
// until the result is taken; a result taken in the same cycle frees the slot.
// Reset clears the encoder, empties the result register and loads four
// frames per message and a frame period of 184 ticks.
module pulse_width_radio_frame_encoder #(
	parameter int FRAME_STORE_BYTES = 16,
	parameter int BODY_BITS         = 28
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            op,
	input  logic [31:0]                     message_word,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            line_data,
	output logic                            tx_active,
	output logic                            busy_res,
	output logic                            send_dropped,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [pwrfe_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pwrfe_pkg::*;

	logic       in_acc;
	logic [3:0] frames_q;
	logic [7:0] period_q;
	res_t       res_next;
	res_t       res_q;
	logic       out_valid_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_acc    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RESET;
			period_q <= PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FRAMES: frames_q <= cfg_data[3:0];
				CFG_PERIOD: period_q <= cfg_data[7:0];
				default:    ;
			endcase
		end
	end

	pwrfe_core #(
		.FRAME_STORE_BYTES(FRAME_STORE_BYTES),
		.BODY_BITS        (BODY_BITS)
	) u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (in_acc),
		.op                (op),
		.message_word      (message_word),
		.frames_per_message(frames_q),
		.frame_period_ticks(period_q),
		.res               (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_q <= res_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign line_data    = res_q.line_data;
	assign tx_active    = res_q.tx_active;
	assign busy_res     = res_q.busy_res;
	assign send_dropped = res_q.send_dropped;

	a_enable_implies_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!tx_active || busy_res))
		else $error("radio enabled while not busy");

	a_tick_never_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && op == OP_TICK) |=> !send_dropped)
		else $error("tick word flagged as dropped send");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	a_drop_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && op == OP_SEND && !res_next.send_dropped) |=> busy_res)
		else $error("accepted send did not start a message");

endmodule
